// ===== sv/tcrf_pkg.sv =====
// Shared types, constants and helper functions for the telemetry CRC RTTY framer.
package tcrf_pkg;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_BIT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_LEADING   = 1'b1;
    localparam logic [1:0] STOP_BIT_COUNT_RST = 2'd2;
    localparam logic [1:0] SKIP_LEADING_RST   = 2'd2;

    // Input commands.
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // CRC-16/CCITT.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [1:0]  POS_MAX  = 2'd3;

    // Line framing: bit slot numbers within one character.
    localparam logic [3:0] BIT_START = 4'd0;
    localparam logic [3:0] BIT_DATA0 = 4'd1;
    localparam logic [3:0] BIT_DATA6 = 4'd7;
    localparam logic [3:0] BIT_STOP1 = 4'd8;
    localparam logic [3:0] BIT_STOP2 = 4'd9;

    // Trailer character slots.
    localparam logic [2:0] TRL_STAR = 3'd0;
    localparam logic [2:0] TRL_D3   = 3'd1;
    localparam logic [2:0] TRL_D2   = 3'd2;
    localparam logic [2:0] TRL_D1   = 3'd3;
    localparam logic [2:0] TRL_D0   = 3'd4;
    localparam logic [2:0] TRL_NL   = 3'd5;
    localparam logic [6:0] CH_STAR    = 7'h2A;
    localparam logic [6:0] CH_NEWLINE = 7'h0A;

    // Queue between the front and the back.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic       command;
        logic [7:0] char_code;
    } t_in_item;

    typedef struct packed {
        logic line_level;
        logic last_bit;
    } t_out_item;

    // One unit of work for the serializer: a character, or a trailer with its CRC.
    typedef struct packed {
        logic        is_trailer;
        logic [15:0] payload;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (r[15]) begin
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

    function automatic logic [6:0] hex_ascii(input logic [3:0] v);
        logic [6:0] r;
        if (v < 4'd10) begin
            r = 7'h30 + {3'd0, v};
        end else begin
            r = 7'h37 + {3'd0, v};
        end
        return r;
    endfunction

endpackage

// ===== sv/tcrf_front.sv =====
// Front end: configuration registers, input acceptance, CRC and sentence position tracking.
module tcrf_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tcrf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tcrf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  tcrf_pkg::t_in_item                 i_in_data,
    input  tcrf_pkg::t_q_status                i_q_status,
    output logic                               o_q_push,
    output tcrf_pkg::t_job                     o_q_job,
    output logic                               o_two_stops
);

    logic [1:0]  r_stop_cnt;
    logic [1:0]  r_skip;
    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic [1:0]  r_pos;
    logic [1:0]  n_pos;
    logic        accept;

    assign o_in_stall  = i_q_status.full;
    assign accept      = i_in_valid && !i_q_status.full;
    assign o_q_push    = accept;
    assign o_two_stops = r_stop_cnt[1];

    always_comb begin
        o_q_job.is_trailer = (i_in_data.command == tcrf_pkg::CMD_END);
        if (i_in_data.command == tcrf_pkg::CMD_END) begin
            o_q_job.payload = r_crc;
        end else begin
            o_q_job.payload = {8'h00, i_in_data.char_code};
        end
    end

    always_comb begin
        n_crc = r_crc;
        n_pos = r_pos;
        if (accept) begin
            if (i_in_data.command == tcrf_pkg::CMD_END) begin
                n_crc = tcrf_pkg::CRC_INIT;
                n_pos = 2'd0;
            end else begin
                if (r_pos >= r_skip) begin
                    n_crc = tcrf_pkg::crc_byte(r_crc, i_in_data.char_code);
                end
                if (r_pos != tcrf_pkg::POS_MAX) begin
                    n_pos = r_pos + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_cnt <= tcrf_pkg::STOP_BIT_COUNT_RST;
            r_skip     <= tcrf_pkg::SKIP_LEADING_RST;
            r_crc      <= tcrf_pkg::CRC_INIT;
            r_pos      <= 2'd0;
        end else begin
            r_crc <= n_crc;
            r_pos <= n_pos;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tcrf_pkg::CFG_STOP_BIT_COUNT: r_stop_cnt <= i_cfg_data;
                    tcrf_pkg::CFG_SKIP_LEADING:   r_skip     <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== sv/tcrf_queue.sv =====
// Small job queue that decouples the front end from the line serializer.
module tcrf_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  tcrf_pkg::t_job       i_job,
    input  logic                 i_pop,
    output tcrf_pkg::t_job       o_job,
    output tcrf_pkg::t_q_status  o_status
);

    tcrf_pkg::t_job                   r_mem [tcrf_pkg::Q_DEPTH];
    logic [tcrf_pkg::Q_PTR_W-1:0]     r_wr_ptr;
    logic [tcrf_pkg::Q_PTR_W-1:0]     r_rd_ptr;
    logic [tcrf_pkg::Q_CNT_W-1:0]     r_count;
    logic                             do_push;
    logic                             do_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == tcrf_pkg::Q_CNT_W'(tcrf_pkg::Q_DEPTH));
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_job          = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == tcrf_pkg::Q_PTR_W'(tcrf_pkg::Q_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == tcrf_pkg::Q_PTR_W'(tcrf_pkg::Q_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= tcrf_pkg::Q_CNT_W'(tcrf_pkg::Q_DEPTH))
        else $error("queue count beyond depth");

endmodule

// ===== sv/tcrf_back.sv =====
// Back end: serializes queued jobs into framed RTTY line bits through an output register.
module tcrf_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_two_stops,
    input  tcrf_pkg::t_q_status  i_q_status,
    input  tcrf_pkg::t_job       i_q_job,
    output logic                 o_q_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output tcrf_pkg::t_out_item  o_out_data
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SEND = 2'b10
    } t_back_state;

    t_back_state          r_state;
    t_back_state          n_state;
    tcrf_pkg::t_job       r_job;
    logic [2:0]           r_char_idx;
    logic [2:0]           n_char_idx;
    logic [3:0]           r_bit_idx;
    logic [3:0]           n_bit_idx;
    logic                 r_out_valid;
    tcrf_pkg::t_out_item  r_out_data;
    logic                 out_ready;
    logic                 advance;
    logic [6:0]           cur_char;
    logic [2:0]           data_sel;
    logic                 level;
    logic [3:0]           last_slot;
    logic                 char_last;
    logic                 item_last;

    assign out_ready = !r_out_valid || !i_out_stall;
    assign advance   = (r_state == ST_SEND) && out_ready;
    assign last_slot = i_two_stops ? tcrf_pkg::BIT_STOP2 : tcrf_pkg::BIT_STOP1;
    assign char_last = (r_bit_idx == last_slot);
    assign item_last = char_last && (!r_job.is_trailer || r_char_idx == tcrf_pkg::TRL_NL);
    assign o_q_pop   = !i_q_status.empty && ((r_state == ST_IDLE) || (advance && item_last));

    always_comb begin
        if (r_job.is_trailer) begin
            case (r_char_idx)
                tcrf_pkg::TRL_STAR: cur_char = tcrf_pkg::CH_STAR;
                tcrf_pkg::TRL_D3:   cur_char = tcrf_pkg::hex_ascii(r_job.payload[15:12]);
                tcrf_pkg::TRL_D2:   cur_char = tcrf_pkg::hex_ascii(r_job.payload[11:8]);
                tcrf_pkg::TRL_D1:   cur_char = tcrf_pkg::hex_ascii(r_job.payload[7:4]);
                tcrf_pkg::TRL_D0:   cur_char = tcrf_pkg::hex_ascii(r_job.payload[3:0]);
                default:            cur_char = tcrf_pkg::CH_NEWLINE;
            endcase
        end else begin
            cur_char = r_job.payload[6:0];
        end
    end

    assign data_sel = r_bit_idx[2:0] - 3'd1;

    always_comb begin
        if (r_bit_idx == tcrf_pkg::BIT_START) begin
            level = 1'b0;
        end else if (r_bit_idx inside {[tcrf_pkg::BIT_DATA0:tcrf_pkg::BIT_DATA6]}) begin
            level = cur_char[data_sel];
        end else begin
            level = 1'b1;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_char_idx = r_char_idx;
        n_bit_idx  = r_bit_idx;
        if (o_q_pop) begin
            n_state    = ST_SEND;
            n_char_idx = tcrf_pkg::TRL_STAR;
            n_bit_idx  = tcrf_pkg::BIT_START;
        end else if (advance) begin
            if (item_last) begin
                n_state = ST_IDLE;
            end else if (char_last) begin
                n_char_idx = r_char_idx + 3'd1;
                n_bit_idx  = tcrf_pkg::BIT_START;
            end else begin
                n_bit_idx = r_bit_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job <= i_q_job;
        end
        if (advance) begin
            r_out_data.line_level <= level;
            r_out_data.last_bit   <= item_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_char_idx  <= tcrf_pkg::TRL_STAR;
            r_bit_idx   <= tcrf_pkg::BIT_START;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_char_idx <= n_char_idx;
            r_bit_idx  <= n_bit_idx;
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // The final bit of every item is a stop bit.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data.last_bit |-> r_out_data.line_level)
        else $error("last bit is not a stop bit");

    // A start slot always drives the line low.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_bit_idx == tcrf_pkg::BIT_START |=> !r_out_data.line_level)
        else $error("start bit not low");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SEND |-> r_bit_idx <= tcrf_pkg::BIT_STOP2)
        else $error("bit slot out of range");

    // Plain characters never leave the first character slot.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SEND && !r_job.is_trailer |-> r_char_idx == tcrf_pkg::TRL_STAR)
        else $error("character slot moved on a plain character");

endmodule

// ===== sv/telemetry_crc_rtty_framer_unit.sv =====
// Top level of the telemetry CRC RTTY framer: front end, job queue and line serializer.
//
//  Channel  | Valid        | Stall        | Payload
//  ---------+--------------+--------------+------------------------------------
//  input    | i_in_valid   | o_in_stall   | i_in_data  (command, char_code)
//  output   | o_out_valid  | i_out_stall  | o_out_data (line_level, last_bit)
//  config   | i_cfg_we     | none         | i_cfg_index, i_cfg_data
//
// A character item yields 9 or 10 line bits, one per cycle while the output does not stall;
// an end-of-sentence item yields 54 or 60. The serializer, emitting one bit a cycle, sets
// the rate of a sustained stream of characters.
// When the block is idle, an item passes the queue, the job register and the output register.
// Reset is synchronous and active low; it restores both registers and sets the CRC to 0xFFFF.
// A stall on the output holds the serializer; the two-entry queue fills and then stalls input.
module telemetry_crc_rtty_framer_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tcrf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tcrf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  tcrf_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output tcrf_pkg::t_out_item             o_out_data
);

    tcrf_pkg::t_q_status q_status;
    tcrf_pkg::t_job      push_job;
    tcrf_pkg::t_job      pop_job;
    logic                q_push;
    logic                q_pop;
    logic                two_stops;

    tcrf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_q_status  (q_status),
        .o_q_push    (q_push),
        .o_q_job     (push_job),
        .o_two_stops (two_stops)
    );

    tcrf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_job    (push_job),
        .i_pop    (q_pop),
        .o_job    (pop_job),
        .o_status (q_status)
    );

    tcrf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_two_stops (two_stops),
        .i_q_status  (q_status),
        .i_q_job     (pop_job),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
